[design/mdb_pkg.sv]
// Shared types, widths, register indexes and reset values for the Mandelbrot
// escape-time pixel block. No dependencies.
`timescale 1ns / 1ps

package mdb_pkg;

    // Field and number widths
    localparam int Q_W        = 32;   // signed Q4.28 coordinate
    localparam int FRAC_W     = 28;
    localparam int COORD_W    = 12;   // pixel column / row
    localparam int DIM_W      = 13;   // image width / height register
    localparam int LIM_W      = 10;   // iteration limit and count
    localparam int GRAY_W     = 8;
    localparam int CFG_ADDR_W = 3;

    localparam int MAX_DIMENSION  = 4096;
    localparam int MAX_ITERATIONS = 1023;
    localparam int GRAY_MAX       = 255;

    // Coordinate mapping: index * (high - low) and its magnitude
    localparam int DIFF_W = Q_W + 1;
    localparam int PROD_W = DIFF_W + COORD_W + 1;
    localparam int DIV_W  = PROD_W - 2;
    localparam int REM_W  = DIM_W + 1;
    localparam int WIDE_W = PROD_W;

    // Iteration: floored squares and doubled cross product
    localparam int SQ_W  = 2 * Q_W - FRAC_W;
    localparam int XY2_W = SQ_W + 1;
    localparam int ESCAPE_BOUND = 4 << FRAC_W;

    // Gray level: count * 255 + limit - 1 over limit
    localparam int GRAY_NUM_W = LIM_W + GRAY_W + 1;
    localparam int MAP_STEPS  = DIV_W;
    localparam int GRAY_STEPS = GRAY_NUM_W;
    localparam int STEP_W     = $clog2(MAP_STEPS);

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH     = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT    = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_ITERATION_LIMIT = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_REAL_LOW        = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] CFG_REAL_HIGH       = CFG_ADDR_W'(4);
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAG_LOW        = CFG_ADDR_W'(5);
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAG_HIGH       = CFG_ADDR_W'(6);

    // Register reset values
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH     = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT    = DIM_W'(480);
    localparam logic [LIM_W-1:0] RST_ITERATION_LIMIT = LIM_W'(80);
    localparam logic [Q_W-1:0]   RST_REAL_LOW        = Q_W'(-671088640);
    localparam logic [Q_W-1:0]   RST_REAL_HIGH       = Q_W'(268435456);
    localparam logic [Q_W-1:0]   RST_IMAG_LOW        = Q_W'(-268435456);
    localparam logic [Q_W-1:0]   RST_IMAG_HIGH       = Q_W'(268435456);

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // register mapping products from the request
        logic map_load;   // load both divider lanes with |product| / size
        logic div_step;   // one restoring-division step on every lane
        logic map_fin;    // form c, clear z and the count
        logic it_mul;     // register x*x, y*y, 2*x*y
        logic it_add;     // update z, advance the count
        logic gray_load;  // load lane 0 with the gray-level division
        logic out_load;   // capture the result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic at_limit;
        logic escaped;
        logic out_free;
    } t_dp_stat;

    // Saturate a wide signed value to the Q4.28 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic fits;
        fits = (&v[WIDE_W-1:Q_W-1]) || !(|v[WIDE_W-1:Q_W-1]);
        if (fits) begin
            return v[Q_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            return {1'b0, {(Q_W-1){1'b1}}};
        end
    endfunction

endpackage

[design/mdb_ctrl.sv]
// Sequencer for the Mandelbrot pixel block: one-hot state machine issuing
// datapath commands. Depends on mdb_pkg.
`timescale 1ns / 1ps

module mdb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mdb_pkg::t_dp_stat i_stat,
    output mdb_pkg::t_dp_cmd  o_cmd
);
    import mdb_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_MAP_LOAD  = 9'b000000010,
        S_MAP_DIV   = 9'b000000100,
        S_MAP_FIN   = 9'b000001000,
        S_IT_MUL    = 9'b000010000,
        S_IT_ADD    = 9'b000100000,
        S_GRAY_LOAD = 9'b001000000,
        S_GRAY_DIV  = 9'b010000000,
        S_OUT       = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MAP_LOAD;
                end
            end
            S_MAP_LOAD: begin
                o_cmd.map_load = 1'b1;
                n_step         = STEP_W'(MAP_STEPS - 1);
                n_state        = S_MAP_DIV;
            end
            S_MAP_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_MAP_FIN;
                end
            end
            S_MAP_FIN: begin
                o_cmd.map_fin = 1'b1;
                n_state       = S_IT_MUL;
            end
            S_IT_MUL: begin
                if (i_stat.at_limit) begin
                    n_state = S_GRAY_LOAD;
                end else begin
                    o_cmd.it_mul = 1'b1;
                    n_state      = S_IT_ADD;
                end
            end
            S_IT_ADD: begin
                if (i_stat.escaped) begin
                    n_state = S_GRAY_LOAD;
                end else begin
                    o_cmd.it_add = 1'b1;
                    n_state      = S_IT_MUL;
                end
            end
            S_GRAY_LOAD: begin
                o_cmd.gray_load = 1'b1;
                n_step          = STEP_W'(GRAY_STEPS - 1);
                n_state         = S_GRAY_DIV;
            end
            S_GRAY_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> !o_in_ready)
        else $error("request accepted while previous pixel still in work");

    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command in a cycle");

    a_no_update_on_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.it_add |-> !i_stat.escaped)
        else $error("z updated after escape");

endmodule

[design/mdb_dpath.sv]
// Datapath for the Mandelbrot pixel block: config registers, coordinate
// mapping, two-lane serial divider, z iteration and output register. Depends on mdb_pkg.
`timescale 1ns / 1ps

module mdb_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [mdb_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [mdb_pkg::Q_W-1:0]         i_cfg_wdata,
    input  logic [mdb_pkg::COORD_W-1:0]     i_column,
    input  logic [mdb_pkg::COORD_W-1:0]     i_row,
    input  mdb_pkg::t_dp_cmd                i_cmd,
    output mdb_pkg::t_dp_stat               o_stat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mdb_pkg::GRAY_W-1:0]      o_gray_level,
    output logic [mdb_pkg::LIM_W-1:0]       o_iteration_count
);
    import mdb_pkg::*;

    // Configuration
    logic [DIM_W-1:0]  r_image_width, r_image_height;
    logic [LIM_W-1:0]  r_iteration_limit;
    logic [Q_W-1:0]    r_real_low, r_real_high, r_imag_low, r_imag_high;

    // Mapping and divider lanes: lane 0 real / gray level, lane 1 imaginary
    logic signed [PROD_W-1:0] r_map_prod [2];
    logic [DIV_W-1:0]         r_dnum [2];
    logic [DIV_W-1:0]         r_dquo [2];
    logic [REM_W-1:0]         r_drem [2];
    logic [DIM_W-1:0]         r_dden [2];
    logic                     r_dneg [2];

    // Iteration
    logic signed [Q_W-1:0]    r_cx, r_cy, r_x, r_y;
    logic [SQ_W-1:0]          r_xx, r_yy;
    logic signed [XY2_W-1:0]  r_xy2;
    logic [LIM_W-1:0]         r_count;

    // Output register
    logic                     r_out_valid;
    logic [GRAY_W-1:0]        r_out_gray;
    logic [LIM_W-1:0]         r_out_count;

    // Combinational
    logic [COORD_W-1:0]        idx [2];
    logic [Q_W-1:0]            lo [2];
    logic [Q_W-1:0]            hi [2];
    logic [DIM_W-1:0]          size [2];
    logic [DIM_W-1:0]          map_den [2];
    logic signed [DIFF_W-1:0]  diff [2];
    logic signed [PROD_W-1:0]  map_prod_nx [2];
    logic signed [PROD_W-1:0]  prod_neg [2];
    logic [DIV_W-1:0]          map_mag [2];
    logic [REM_W-1:0]          div_trial [2];
    logic                      div_ge [2];
    logic [REM_W-1:0]          div_rem_nx [2];
    logic signed [WIDE_W-1:0]  q_mag [2];
    logic signed [WIDE_W-1:0]  q_sgn [2];
    logic signed [WIDE_W-1:0]  lo_w [2];
    logic signed [Q_W-1:0]     c_nx [2];

    logic signed [2*Q_W-1:0]   p_xx, p_yy, p_xy;
    logic [SQ_W:0]             esc_sum;
    logic signed [WIDE_W-1:0]  w_xx, w_yy, w_xy2, w_cx, w_cy;
    logic signed [Q_W-1:0]     x_nx, y_nx;
    logic [LIM_W-1:0]          lim_eff;
    logic [GRAY_NUM_W-1:0]     gray_num;
    logic [GRAY_W-1:0]         gray_nx;

    assign idx[0]  = i_column;
    assign idx[1]  = i_row;
    assign lo[0]   = r_real_low;
    assign lo[1]   = r_imag_low;
    assign hi[0]   = r_real_high;
    assign hi[1]   = r_imag_high;
    assign size[0] = r_image_width;
    assign size[1] = r_image_height;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            // a zero size counts as one, an oversized one as the maximum
            if (size[l] == '0) begin
                map_den[l] = DIM_W'(1);
            end else if (size[l] > DIM_W'(MAX_DIMENSION)) begin
                map_den[l] = DIM_W'(MAX_DIMENSION);
            end else begin
                map_den[l] = size[l];
            end
            diff[l]        = $signed({hi[l][Q_W-1], hi[l]}) - $signed({lo[l][Q_W-1], lo[l]});
            map_prod_nx[l] = $signed({1'b0, idx[l]}) * diff[l];
            prod_neg[l]    = -r_map_prod[l];
            map_mag[l]     = r_map_prod[l][PROD_W-1] ? prod_neg[l][DIV_W-1:0]
                                                     : r_map_prod[l][DIV_W-1:0];
            // restoring division, one quotient bit per step
            div_trial[l]   = {r_drem[l][REM_W-2:0], r_dnum[l][DIV_W-1]};
            div_ge[l]      = div_trial[l] >= {1'b0, r_dden[l]};
            div_rem_nx[l]  = div_ge[l] ? div_trial[l] - {1'b0, r_dden[l]} : div_trial[l];
            // truncated signed quotient plus low edge
            q_mag[l]       = {2'b00, r_dquo[l]};
            q_sgn[l]       = r_dneg[l] ? -q_mag[l] : q_mag[l];
            lo_w[l]        = $signed(lo[l]);
            c_nx[l]        = sat_q(lo_w[l] + q_sgn[l]);
        end
    end

    assign p_xx    = r_x * r_x;
    assign p_yy    = r_y * r_y;
    assign p_xy    = r_x * r_y;
    assign esc_sum = {1'b0, r_xx} + {1'b0, r_yy};
    assign w_xx    = $signed({{(WIDE_W-SQ_W){1'b0}}, r_xx});
    assign w_yy    = $signed({{(WIDE_W-SQ_W){1'b0}}, r_yy});
    assign w_xy2   = r_xy2;
    assign w_cx    = r_cx;
    assign w_cy    = r_cy;
    assign x_nx    = sat_q(w_xx - w_yy + w_cx);
    assign y_nx    = sat_q(w_xy2 + w_cy);

    assign lim_eff = (r_iteration_limit > LIM_W'(MAX_ITERATIONS)) ? LIM_W'(MAX_ITERATIONS)
                                                                   : r_iteration_limit;
    assign gray_num = {1'b0, r_count, {GRAY_W{1'b0}}} - GRAY_NUM_W'(r_count)
                    + GRAY_NUM_W'(lim_eff) - GRAY_NUM_W'(1);
    assign gray_nx  = (lim_eff == '0) ? GRAY_W'(GRAY_MAX)
                                      : GRAY_W'(GRAY_MAX) - r_dquo[0][GRAY_W-1:0];

    assign o_stat.at_limit = (r_count == lim_eff);
    assign o_stat.escaped  = (esc_sum >= (SQ_W + 1)'(ESCAPE_BOUND));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_gray_level      = r_out_gray;
    assign o_iteration_count = r_out_count;

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= RST_IMAGE_WIDTH;
            r_image_height    <= RST_IMAGE_HEIGHT;
            r_iteration_limit <= RST_ITERATION_LIMIT;
            r_real_low        <= RST_REAL_LOW;
            r_real_high       <= RST_REAL_HIGH;
            r_imag_low        <= RST_IMAG_LOW;
            r_imag_high       <= RST_IMAG_HIGH;
            r_count           <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_IMAGE_WIDTH:     r_image_width     <= i_cfg_wdata[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_wdata[DIM_W-1:0];
                    CFG_ITERATION_LIMIT: r_iteration_limit <= i_cfg_wdata[LIM_W-1:0];
                    CFG_REAL_LOW:        r_real_low        <= i_cfg_wdata;
                    CFG_REAL_HIGH:       r_real_high       <= i_cfg_wdata;
                    CFG_IMAG_LOW:        r_imag_low        <= i_cfg_wdata;
                    CFG_IMAG_HIGH:       r_imag_high       <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.map_fin) begin
                r_count <= '0;
            end else if (i_cmd.it_add) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            if (i_cmd.accept) begin
                r_map_prod[l] <= map_prod_nx[l];
            end
            if (i_cmd.map_load) begin
                r_dnum[l] <= map_mag[l];
                r_dneg[l] <= r_map_prod[l][PROD_W-1];
                r_dden[l] <= map_den[l];
                r_drem[l] <= '0;
                r_dquo[l] <= '0;
            end else if (i_cmd.div_step) begin
                r_dnum[l] <= {r_dnum[l][DIV_W-2:0], 1'b0};
                r_drem[l] <= div_rem_nx[l];
                r_dquo[l] <= {r_dquo[l][DIV_W-2:0], div_ge[l]};
            end
        end
        // gray-level division rides on lane 0, numerator aligned to the top
        if (i_cmd.gray_load) begin
            r_dnum[0] <= {gray_num, {(DIV_W-GRAY_NUM_W){1'b0}}};
            r_dneg[0] <= 1'b0;
            r_dden[0] <= DIM_W'(lim_eff);
            r_drem[0] <= '0;
            r_dquo[0] <= '0;
        end
        if (i_cmd.map_fin) begin
            r_cx <= c_nx[0];
            r_cy <= c_nx[1];
            r_x  <= '0;
            r_y  <= '0;
        end else if (i_cmd.it_add) begin
            r_x <= x_nx;
            r_y <= y_nx;
        end
        if (i_cmd.it_mul) begin
            r_xx  <= p_xx[2*Q_W-1:FRAC_W];
            r_yy  <= p_yy[2*Q_W-1:FRAC_W];
            r_xy2 <= p_xy[2*Q_W-1:FRAC_W-1];
        end
        if (i_cmd.out_load) begin
            r_out_gray  <= gray_nx;
            r_out_count <= r_count;
        end
    end

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + 1'b1) || (r_count == '0))
        else $error("iteration count jumped");

    a_gray_for_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_count == '0)) |-> (r_out_gray == GRAY_W'(GRAY_MAX)))
        else $error("zero iterations must give full gray level");

endmodule

[design/mandelbrot_escape_time_pixel.sv]
// Each pixel passes through a 44-step mapping division, z iterations (a multiply
//   state, then an add/escape state) and a 19-step gray division.
// A new request is taken only once the previous result sits in the output
//   register, even while that result waits downstream.
// Reset: synchronous, active low; clears control state and loads the default
//   640x480 window [-2.5, 1.0] x [-1.0, 1.0] with a limit of 80.
// Top level of the Mandelbrot escape-time pixel block; depends on mdb_pkg,
// mdb_ctrl and mdb_dpath.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes, index per register list
    input  logic                            i_cfg_wr_en,
    input  logic [mdb_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [mdb_pkg::Q_W-1:0]         i_cfg_wdata,
    // pixel requests
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [23:0]                     i_s_axis_tdata,  // [11:0] column, [23:12] row
    // results
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [23:0]                     o_m_axis_tdata   // [7:0] gray_level,
                                                             // [17:8] iteration_count, [23:18] zero
);
    import mdb_pkg::*;

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [GRAY_W-1:0]  gray_level;
    logic [LIM_W-1:0]   iteration_count;

    // The controller walks each pixel through: map request to c with a
    // shared serial divider, iterate z = z*z + c (multiply cycle, then
    // add/escape cycle), divide for the gray level, then hand off.
    mdb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath owns the configuration registers, all arithmetic and the
    // output register that decouples the result from the next request.
    mdb_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_column          (i_s_axis_tdata[COORD_W-1:0]),
        .i_row             (i_s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_out_valid       (o_m_axis_tvalid),
        .i_out_ready       (i_m_axis_tready),
        .o_gray_level      (gray_level),
        .o_iteration_count (iteration_count)
    );

    // Pack the result fields from the lowest bit up, zero-fill to whole bytes
    assign o_m_axis_tdata = {{(24 - GRAY_W - LIM_W){1'b0}}, iteration_count, gray_level};

endmodule
